[design/hbka_pkg.sv]
// Shared constants and helper functions for the Helmholtz kernel accumulator.
package hbka_pkg;

    localparam logic [19:0] FOURPI_Q    = 20'd823550;
    localparam logic [31:0] INV2PI_Q    = 32'd683565276;
    localparam logic [31:0] HALFPI_Q30  = 32'd1686629713;
    localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
    localparam logic [4:0]  CORDIC_LAST = 5'd29;

    localparam logic        REG_WAVE_NUMBER = 1'b0;
    localparam logic        REG_RHO_C       = 1'b1;
    localparam logic [31:0] WAVE_RESET      = 32'd65536;
    localparam logic [31:0] RHOC_RESET      = 32'd27066368;

    localparam logic signed [48:0] LIM49     = 49'sh0_7FFF_FFFF_FFFF;
    localparam logic signed [47:0] LIM48_POS = 48'sh7FFF_FFFF_FFFF;
    localparam logic signed [47:0] LIM48_NEG = 48'sh8000_0000_0001;

    // arctan(2^-i) in Q30
    function automatic logic [31:0] f_atan(input logic [4:0] i);
        logic [31:0] v;
        case (i)
            5'd0:  v = 32'd843314857;
            5'd1:  v = 32'd497837829;
            5'd2:  v = 32'd263043837;
            5'd3:  v = 32'd133525159;
            5'd4:  v = 32'd67021687;
            5'd5:  v = 32'd33543516;
            5'd6:  v = 32'd16775851;
            5'd7:  v = 32'd8388437;
            5'd8:  v = 32'd4194283;
            5'd9:  v = 32'd2097149;
            5'd10: v = 32'd1048576;
            5'd11: v = 32'd524288;
            5'd12: v = 32'd262144;
            5'd13: v = 32'd131072;
            5'd14: v = 32'd65536;
            5'd15: v = 32'd32768;
            5'd16: v = 32'd16384;
            5'd17: v = 32'd8192;
            5'd18: v = 32'd4096;
            5'd19: v = 32'd2048;
            5'd20: v = 32'd1024;
            5'd21: v = 32'd512;
            5'd22: v = 32'd256;
            5'd23: v = 32'd128;
            5'd24: v = 32'd64;
            5'd25: v = 32'd32;
            5'd26: v = 32'd16;
            5'd27: v = 32'd8;
            5'd28: v = 32'd4;
            5'd29: v = 32'd2;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

    function automatic logic signed [31:0] f_sat32(input logic signed [32:0] d);
        logic signed [31:0] v;
        if (d[32] != d[31]) begin
            v = d[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end else begin
            v = d[31:0];
        end
        return v;
    endfunction

    function automatic logic [63:0] f_mag64(input logic signed [63:0] a);
        logic [63:0] v;
        v = a[63] ? (~a + 64'd1) : a;
        return v;
    endfunction

    function automatic logic signed [47:0] f_sat48(input logic signed [48:0] s);
        logic signed [47:0] v;
        if (s > LIM49) begin
            v = LIM48_POS;
        end else if (s < -LIM49) begin
            v = LIM48_NEG;
        end else begin
            v = s[47:0];
        end
        return v;
    endfunction

    function automatic logic [61:0] f_sh30_lim62(input logic [127:0] p);
        logic [97:0] s;
        s = p[127:30];
        return (|s[97:62]) ? {62{1'b1}} : s[61:0];
    endfunction

    function automatic logic [60:0] f_sh30_lim61(input logic [127:0] p);
        logic [97:0] s;
        s = p[127:30];
        return (|s[97:61]) ? {61{1'b1}} : s[60:0];
    endfunction

    function automatic logic [46:0] f_sh16_lim47(input logic [127:0] p);
        logic [111:0] s;
        s = p[127:16];
        return (|s[111:47]) ? {47{1'b1}} : s[46:0];
    endfunction

endpackage

[design/helmholtz_bem_kernel_accumulate.sv]
// Helmholtz BEM kernel accumulator: sequencer around one shared multiplier, divider,
// square-root and CORDIC datapath.
//
// Usage: one request on the input channel is one quadrature point (centre, source
// point, weight, normal, last_point). Each request yields one result: the two cache
// factors of the point, and on the last point also the two complex sums (re and im),
// after which the accumulators clear. wave_number and rho_c are written over the APB
// port at byte addresses 0 and 4, by the user only while the block is idle (not enforced).
// Datapath: the bulk of the work is one 32x32 multiplier reused for 21 products (4
// partial products for the wide ones), a 32-step square root, two 47-step restoring
// divisions and a 30-step CORDIC, all in series. o_in_stall is high for the whole
// computation.
// The result sits in an output register: if the receiver stalls, the next request is
// still accepted and computed, and only the final write-back waits for the register
// to empty.
// Reset (synchronous, active low) returns the registers to their defaults, clears
// the accumulators and drops any request in flight.
module helmholtz_bem_kernel_accumulate
    import hbka_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic signed [31:0] i_center_x,
    input  logic signed [31:0] i_center_y,
    input  logic signed [31:0] i_center_z,
    input  logic signed [31:0] i_gauss_x,
    input  logic signed [31:0] i_gauss_y,
    input  logic signed [31:0] i_gauss_z,
    input  logic [30:0]        i_weight,
    input  logic signed [15:0] i_normal_x,
    input  logic signed [15:0] i_normal_y,
    input  logic signed [15:0] i_normal_z,
    input  logic               i_last_point,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [47:0] o_cache_single,
    output logic signed [47:0] o_cache_double,
    output logic signed [47:0] o_single_re,
    output logic signed [47:0] o_single_im,
    output logic signed [47:0] o_double_re,
    output logic signed [47:0] o_double_im,
    output logic               o_sums_valid
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_LAUNCH = 4'd1;
    localparam logic [3:0] S_MUL    = 4'd2;
    localparam logic [3:0] S_MWAIT  = 4'd3;
    localparam logic [3:0] S_DONE   = 4'd4;
    localparam logic [3:0] S_SQRT   = 4'd5;
    localparam logic [3:0] S_DIVCHK = 4'd6;
    localparam logic [3:0] S_DIVRUN = 4'd7;
    localparam logic [3:0] S_DIVEND = 4'd8;
    localparam logic [3:0] S_CORD   = 4'd9;
    localparam logic [3:0] S_OUT    = 4'd10;

    localparam logic [4:0] OP_RXX  = 5'd0;
    localparam logic [4:0] OP_RYY  = 5'd1;
    localparam logic [4:0] OP_RZZ  = 5'd2;
    localparam logic [4:0] OP_SQRT = 5'd3;
    localparam logic [4:0] OP_DX   = 5'd4;
    localparam logic [4:0] OP_DY   = 5'd5;
    localparam logic [4:0] OP_DZ   = 5'd6;
    localparam logic [4:0] OP_PROD = 5'd7;
    localparam logic [4:0] OP_DEN  = 5'd8;
    localparam logic [4:0] OP_DIV1 = 5'd9;
    localparam logic [4:0] OP_WD   = 5'd10;
    localparam logic [4:0] OP_DEN2 = 5'd11;
    localparam logic [4:0] OP_DIV2 = 5'd12;
    localparam logic [4:0] OP_TH   = 5'd13;
    localparam logic [4:0] OP_FR   = 5'd14;
    localparam logic [4:0] OP_PART = 5'd15;
    localparam logic [4:0] OP_CORD = 5'd16;
    localparam logic [4:0] OP_KS   = 5'd17;
    localparam logic [4:0] OP_KC   = 5'd18;
    localparam logic [4:0] OP_KRS  = 5'd19;
    localparam logic [4:0] OP_KRC  = 5'd20;
    localparam logic [4:0] OP_ASR  = 5'd21;
    localparam logic [4:0] OP_ASI  = 5'd22;
    localparam logic [4:0] OP_ADR  = 5'd23;
    localparam logic [4:0] OP_ADI  = 5'd24;
    localparam logic [4:0] OP_OUT  = 5'd25;

    // control and configuration
    logic [3:0]  r_state;
    logic [4:0]  r_op;
    logic [5:0]  r_cnt;
    logic [31:0] r_wave;
    logic [31:0] r_rhoc;

    // captured request
    logic signed [31:0] r_rx, r_ry, r_rz;
    logic [30:0]        r_w;
    logic signed [15:0] r_nx, r_ny, r_nz;
    logic               r_last;

    // intermediate results
    logic [63:0]         r_r2;
    logic [31:0]         r_len;
    logic signed [50:0]  r_dot;
    logic [62:0]         r_prod;
    logic [51:0]         r_den1;
    logic [80:0]         r_wd;
    logic [115:0]        r_den2;
    logic [46:0]         r_cs;
    logic signed [47:0]  r_cd;
    logic [63:0]         r_theta;
    logic [63:0]         r_frac;
    logic signed [32:0]  r_zinit;
    logic signed [33:0]  r_co, r_si;
    logic signed [63:0]  r_fsre, r_fsim, r_t1, r_t2;
    logic signed [47:0]  r_acc_sre, r_acc_sim, r_acc_dre, r_acc_dim;

    // shared multiplier
    logic [63:0]  r_ma, r_mb;
    logic         r_wide;
    logic         r_msign;
    logic [1:0]   r_pi;
    logic [63:0]  r_pp;
    logic [1:0]   r_pps;
    logic         r_ppv;
    logic [127:0] r_pacc;

    // square root
    logic [63:0] r_sv, r_sres, r_sbit;

    // divider
    logic [122:0] r_dnum;
    logic [115:0] r_dden;
    logic [115:0] r_drem;
    logic [46:0]  r_dlo;
    logic [46:0]  r_dq;

    // CORDIC
    logic signed [33:0] r_x, r_y;
    logic signed [32:0] r_z;

    // output register
    logic               r_ov;
    logic signed [47:0] r_o_cs, r_o_cd, r_o_sre, r_o_sim, r_o_dre, r_o_dim;
    logic               r_o_sv;

    logic               n_in_acc;
    logic               n_cfg_wr;
    logic               n_out_load;
    logic signed [31:0] n_rx, n_ry, n_rz;
    logic [31:0]        n_aw, n_bw;
    logic [63:0]        n_pp;
    logic [64:0]        n_sq_sum;
    logic               n_sq_ge;
    logic [63:0]        n_sq_res;
    logic [116:0]       n_dt;
    logic [116:0]       n_dsub;
    logic               n_dge;
    logic               n_dover;
    logic [4:0]         n_ci;
    logic signed [33:0] n_x, n_y;
    logic signed [32:0] n_z;
    logic signed [33:0] n_atan;
    logic [61:0]        n_m62;
    logic [60:0]        n_m61;
    logic [46:0]        n_m47;
    logic signed [63:0] n_e62, n_e61;
    logic signed [47:0] n_v47;
    logic signed [50:0] n_dterm;
    logic [63:0]        n_coa, n_sia;
    logic signed [63:0] n_tc, n_ts, n_fdre, n_fdim;
    logic [49:0]        n_dotm;

    assign pready      = 1'b1;
    assign prdata      = (paddr[2] == REG_RHO_C) ? r_rhoc : r_wave;
    assign n_cfg_wr    = psel && penable && pwrite && pready;
    assign o_in_stall  = (r_state != S_IDLE);
    assign n_in_acc    = i_in_valid && !o_in_stall;
    assign n_out_load  = (r_state == S_OUT) && (!r_ov || !i_out_stall);

    assign n_rx = f_sat32($signed({i_center_x[31], i_center_x}) -
                          $signed({i_gauss_x[31], i_gauss_x}));
    assign n_ry = f_sat32($signed({i_center_y[31], i_center_y}) -
                          $signed({i_gauss_y[31], i_gauss_y}));
    assign n_rz = f_sat32($signed({i_center_z[31], i_center_z}) -
                          $signed({i_gauss_z[31], i_gauss_z}));

    // partial product: word select by r_pi, weight 2^(32*(pi0+pi1))
    assign n_aw = r_pi[0] ? r_ma[63:32] : r_ma[31:0];
    assign n_bw = r_pi[1] ? r_mb[63:32] : r_mb[31:0];
    assign n_pp = n_aw * n_bw;

    assign n_sq_sum = {1'b0, r_sres} + {1'b0, r_sbit};
    assign n_sq_ge  = {1'b0, r_sv} >= n_sq_sum;
    assign n_sq_res = n_sq_ge ? ((r_sres >> 1) + r_sbit) : (r_sres >> 1);

    assign n_dover = {40'd0, r_dnum} >= {r_dden, 47'd0};
    assign n_dt    = {r_drem, r_dlo[46]};
    assign n_dge   = n_dt >= {1'b0, r_dden};
    assign n_dsub  = n_dt - {1'b0, r_dden};

    assign n_ci   = r_cnt[4:0];
    assign n_atan = $signed({2'b00, f_atan(n_ci)});
    always_comb begin
        if (!r_z[32]) begin
            n_x = r_x - (r_y >>> n_ci);
            n_y = r_y + (r_x >>> n_ci);
            n_z = r_z - n_atan[32:0];
        end else begin
            n_x = r_x + (r_y >>> n_ci);
            n_y = r_y - (r_x >>> n_ci);
            n_z = r_z + n_atan[32:0];
        end
    end

    assign n_m62 = f_sh30_lim62(r_pacc);
    assign n_m61 = f_sh30_lim61(r_pacc);
    assign n_m47 = f_sh16_lim47(r_pacc);
    assign n_e62 = $signed({2'b00, n_m62});
    assign n_e61 = $signed({3'b000, n_m61});
    assign n_v47 = r_msign ? -$signed({1'b0, n_m47}) : $signed({1'b0, n_m47});
    assign n_dterm = r_msign ? -$signed({4'd0, r_pacc[46:0]}) :
                               $signed({4'd0, r_pacc[46:0]});
    assign n_dotm = f_mag64(64'(r_dot)) [49:0];

    assign n_coa  = f_mag64(64'(r_co));
    assign n_sia  = f_mag64(64'(r_si));
    assign n_tc   = r_co[33] ? -$signed(n_coa >> 14) : $signed(n_coa >> 14);
    assign n_ts   = r_si[33] ? -$signed(n_sia >> 14) : $signed(n_sia >> 14);
    assign n_fdre = -n_tc - r_t1;
    assign n_fdim = -n_ts + r_t2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_op      <= OP_RXX;
            r_ppv     <= 1'b0;
            r_ov      <= 1'b0;
            r_wave    <= WAVE_RESET;
            r_rhoc    <= RHOC_RESET;
            r_acc_sre <= '0;
            r_acc_sim <= '0;
            r_acc_dre <= '0;
            r_acc_dim <= '0;
        end else begin
            if (n_cfg_wr) begin
                if (paddr[2] == REG_RHO_C) begin
                    r_rhoc <= pwdata;
                end else begin
                    r_wave <= pwdata;
                end
            end

            r_ppv <= (r_state == S_MUL);
            if (r_ppv) begin
                r_pacc <= r_pacc + ({64'd0, r_pp} << {r_pps, 5'd0});
            end

            if (n_out_load) begin
                r_ov <= 1'b1;
            end else if (!i_out_stall) begin
                r_ov <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (n_in_acc) begin
                        r_rx    <= n_rx;
                        r_ry    <= n_ry;
                        r_rz    <= n_rz;
                        r_w     <= i_weight;
                        r_nx    <= i_normal_x;
                        r_ny    <= i_normal_y;
                        r_nz    <= i_normal_z;
                        r_last  <= i_last_point;
                        r_op    <= OP_RXX;
                        r_state <= S_LAUNCH;
                    end
                end
                S_LAUNCH: begin
                    r_pi    <= 2'd0;
                    r_pacc  <= '0;
                    r_wide  <= 1'b0;
                    r_msign <= 1'b0;
                    r_state <= S_MUL;
                    unique case (r_op)
                        OP_RXX: begin
                            r_ma <= f_mag64(64'(r_rx));
                            r_mb <= f_mag64(64'(r_rx));
                        end
                        OP_RYY: begin
                            r_ma <= f_mag64(64'(r_ry));
                            r_mb <= f_mag64(64'(r_ry));
                        end
                        OP_RZZ: begin
                            r_ma <= f_mag64(64'(r_rz));
                            r_mb <= f_mag64(64'(r_rz));
                        end
                        OP_SQRT: begin
                            r_sv    <= r_r2;
                            r_sres  <= '0;
                            r_sbit  <= 64'd1 << 62;
                            r_state <= S_SQRT;
                        end
                        OP_DX: begin
                            r_ma    <= f_mag64(64'(r_rx));
                            r_mb    <= f_mag64(64'(r_nx));
                            r_msign <= r_rx[31] ^ r_nx[15];
                        end
                        OP_DY: begin
                            r_ma    <= f_mag64(64'(r_ry));
                            r_mb    <= f_mag64(64'(r_ny));
                            r_msign <= r_ry[31] ^ r_ny[15];
                        end
                        OP_DZ: begin
                            r_ma    <= f_mag64(64'(r_rz));
                            r_mb    <= f_mag64(64'(r_nz));
                            r_msign <= r_rz[31] ^ r_nz[15];
                        end
                        OP_PROD: begin
                            r_ma <= {33'd0, r_w};
                            r_mb <= {32'd0, r_rhoc};
                        end
                        OP_DEN: begin
                            r_ma <= {44'd0, FOURPI_Q};
                            r_mb <= {32'd0, r_len};
                        end
                        OP_DIV1: begin
                            r_dnum  <= {36'd0, r_prod, 24'd0};
                            r_dden  <= {64'd0, r_den1};
                            r_state <= S_DIVCHK;
                        end
                        OP_WD: begin
                            r_ma   <= {33'd0, r_w};
                            r_mb   <= {14'd0, n_dotm};
                            r_wide <= 1'b1;
                        end
                        OP_DEN2: begin
                            r_ma   <= r_r2;
                            r_mb   <= {12'd0, r_den1};
                            r_wide <= 1'b1;
                        end
                        OP_DIV2: begin
                            r_dnum  <= {r_wd, 42'd0};
                            r_dden  <= r_den2;
                            r_state <= S_DIVCHK;
                        end
                        OP_TH: begin
                            r_ma <= {32'd0, r_wave};
                            r_mb <= {32'd0, r_len};
                        end
                        OP_FR: begin
                            r_ma   <= r_theta;
                            r_mb   <= {32'd0, INV2PI_Q};
                            r_wide <= 1'b1;
                        end
                        OP_PART: begin
                            r_ma <= {32'd0, r_frac[61:30]};
                            r_mb <= {32'd0, HALFPI_Q30};
                        end
                        OP_CORD: begin
                            r_x     <= CORDIC_GAIN;
                            r_y     <= '0;
                            r_z     <= r_zinit;
                            r_cnt   <= '0;
                            r_state <= S_CORD;
                        end
                        OP_KS: begin
                            r_ma <= {32'd0, r_wave};
                            r_mb <= n_sia;
                        end
                        OP_KC: begin
                            r_ma <= {32'd0, r_wave};
                            r_mb <= n_coa;
                        end
                        OP_KRS: begin
                            r_ma   <= {16'd0, r_theta[63:16]};
                            r_mb   <= n_sia;
                            r_wide <= 1'b1;
                        end
                        OP_KRC: begin
                            r_ma   <= {16'd0, r_theta[63:16]};
                            r_mb   <= n_coa;
                            r_wide <= 1'b1;
                        end
                        OP_ASR: begin
                            r_ma    <= f_mag64(r_fsre);
                            r_mb    <= {17'd0, r_cs};
                            r_msign <= r_fsre[63];
                            r_wide  <= 1'b1;
                        end
                        OP_ASI: begin
                            r_ma    <= f_mag64(r_fsim);
                            r_mb    <= {17'd0, r_cs};
                            r_msign <= r_fsim[63];
                            r_wide  <= 1'b1;
                        end
                        OP_ADR: begin
                            r_ma    <= f_mag64(n_fdre);
                            r_mb    <= f_mag64(64'(r_cd));
                            r_msign <= n_fdre[63] ^ r_cd[47];
                            r_wide  <= 1'b1;
                        end
                        OP_ADI: begin
                            r_ma    <= f_mag64(n_fdim);
                            r_mb    <= f_mag64(64'(r_cd));
                            r_msign <= n_fdim[63] ^ r_cd[47];
                            r_wide  <= 1'b1;
                        end
                        OP_OUT: begin
                            r_state <= S_OUT;
                        end
                        default: begin
                            r_state <= S_IDLE;
                        end
                    endcase
                end
                S_MUL: begin
                    r_pp  <= n_pp;
                    r_pps <= {1'b0, r_pi[0]} + {1'b0, r_pi[1]};
                    if (!r_wide || r_pi == 2'd3) begin
                        r_state <= S_MWAIT;
                    end else begin
                        r_pi <= r_pi + 2'd1;
                    end
                end
                S_MWAIT: begin
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    case (r_op)
                        OP_RXX:  r_r2   <= r_pacc[63:0];
                        OP_RYY,
                        OP_RZZ:  r_r2   <= r_r2 + r_pacc[63:0];
                        OP_DX:   r_dot  <= n_dterm;
                        OP_DY,
                        OP_DZ:   r_dot  <= r_dot + n_dterm;
                        OP_PROD: r_prod <= r_pacc[62:0];
                        OP_DEN:  r_den1 <= r_pacc[51:0];
                        OP_WD:   r_wd   <= r_pacc[80:0];
                        OP_DEN2: r_den2 <= r_pacc[115:0];
                        OP_TH:   r_theta <= r_pacc[63:0];
                        OP_FR:   r_frac <= r_pacc[63:0];
                        OP_PART: r_zinit <= $signed({1'b0, r_pacc[63:32]});
                        OP_KS:   r_fsre <= r_si[33] ? n_e62 : -n_e62;
                        OP_KC:   r_fsim <= r_co[33] ? -n_e62 : n_e62;
                        OP_KRS:  r_t1   <= r_si[33] ? -n_e61 : n_e61;
                        OP_KRC:  r_t2   <= r_co[33] ? -n_e61 : n_e61;
                        OP_ASR:  r_acc_sre <= f_sat48({r_acc_sre[47], r_acc_sre} +
                                                      {n_v47[47], n_v47});
                        OP_ASI:  r_acc_sim <= f_sat48({r_acc_sim[47], r_acc_sim} +
                                                      {n_v47[47], n_v47});
                        OP_ADR:  r_acc_dre <= f_sat48({r_acc_dre[47], r_acc_dre} +
                                                      {n_v47[47], n_v47});
                        OP_ADI:  r_acc_dim <= f_sat48({r_acc_dim[47], r_acc_dim} +
                                                      {n_v47[47], n_v47});
                        default: ;
                    endcase
                    r_op    <= r_op + 5'd1;
                    r_state <= S_LAUNCH;
                end
                S_SQRT: begin
                    if (n_sq_ge) begin
                        r_sv <= r_sv - n_sq_sum[63:0];
                    end
                    r_sres <= n_sq_res;
                    r_sbit <= r_sbit >> 2;
                    if (r_sbit[0]) begin
                        r_len   <= n_sq_res[31:0];
                        r_op    <= r_op + 5'd1;
                        r_state <= S_LAUNCH;
                    end
                end
                S_DIVCHK: begin
                    // zero divisor (unless the numerator is zero too), or quotient past 47 bits, saturates
                    if (r_dden == '0) begin
                        r_dq    <= (|r_dnum) ? {47{1'b1}} : '0;
                        r_state <= S_DIVEND;
                    end else if (n_dover) begin
                        r_dq    <= {47{1'b1}};
                        r_state <= S_DIVEND;
                    end else begin
                        r_drem  <= {40'd0, r_dnum[122:47]};
                        r_dlo   <= r_dnum[46:0];
                        r_dq    <= '0;
                        r_cnt   <= 6'd46;
                        r_state <= S_DIVRUN;
                    end
                end
                S_DIVRUN: begin
                    r_drem <= n_dge ? n_dsub[115:0] : n_dt[115:0];
                    r_dq   <= {r_dq[45:0], n_dge};
                    r_dlo  <= {r_dlo[45:0], 1'b0};
                    r_cnt  <= r_cnt - 6'd1;
                    if (r_cnt == '0) begin
                        r_state <= S_DIVEND;
                    end
                end
                S_DIVEND: begin
                    if (r_op == OP_DIV1) begin
                        r_cs <= r_dq;
                    end else begin
                        r_cd <= (r_dot > 0) ? -$signed({1'b0, r_dq}) : $signed({1'b0, r_dq});
                    end
                    r_op    <= r_op + 5'd1;
                    r_state <= S_LAUNCH;
                end
                S_CORD: begin
                    r_x <= n_x;
                    r_y <= n_y;
                    r_z <= n_z;
                    if (n_ci == CORDIC_LAST) begin
                        unique case (r_frac[63:62])
                            2'd0: begin r_co <= n_x;  r_si <= n_y;  end
                            2'd1: begin r_co <= -n_y; r_si <= n_x;  end
                            2'd2: begin r_co <= -n_x; r_si <= -n_y; end
                            2'd3: begin r_co <= n_y;  r_si <= -n_x; end
                        endcase
                        r_op    <= r_op + 5'd1;
                        r_state <= S_LAUNCH;
                    end else begin
                        r_cnt <= r_cnt + 6'd1;
                    end
                end
                S_OUT: begin
                    if (n_out_load) begin
                        r_o_cs <= $signed({1'b0, r_cs});
                        r_o_cd <= r_cd;
                        r_o_sv <= r_last;
                        if (r_last) begin
                            r_o_sre   <= r_acc_sre;
                            r_o_sim   <= r_acc_sim;
                            r_o_dre   <= r_acc_dre;
                            r_o_dim   <= r_acc_dim;
                            r_acc_sre <= '0;
                            r_acc_sim <= '0;
                            r_acc_dre <= '0;
                            r_acc_dim <= '0;
                        end else begin
                            r_o_sre <= '0;
                            r_o_sim <= '0;
                            r_o_dre <= '0;
                            r_o_dim <= '0;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid    = r_ov;
    assign o_cache_single = r_o_cs;
    assign o_cache_double = r_o_cd;
    assign o_single_re    = r_o_sre;
    assign o_single_im    = r_o_sim;
    assign o_double_re    = r_o_dre;
    assign o_double_im    = r_o_dim;
    assign o_sums_valid   = r_o_sv;

    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        n_in_acc |=> (r_state == S_LAUNCH && r_op == OP_RXX))
        else $error("request accepted but sequence did not start");

    a_out_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        n_out_load |=> (r_state == S_IDLE && r_ov))
        else $error("result write-back did not complete");

    a_sqrt_bit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SQRT) |-> $onehot(r_sbit))
        else $error("square root bit lost");

    a_div_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIVRUN) |-> (r_drem < r_dden))
        else $error("divider remainder out of range");

    a_acc_sym: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_acc_sre != 48'sh8000_0000_0000) && (r_acc_dre != 48'sh8000_0000_0000))
        else $error("accumulator left symmetric range");

endmodule
